/* hdl/bser_pkg.sv */
// shared types and constants for the bit stuffing emulation remover
`default_nettype none
package bser_pkg;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned SHIFT_W    = 3;
  localparam int unsigned ZRUN_W     = 2;
  localparam int unsigned OUTQ_DEPTH = 4;

  localparam logic [BYTE_W-1:0]  STUFF_BYTE = 8'h02;
  localparam logic [BYTE_W-1:0]  START_BYTE = 8'h01;
  localparam logic [ZRUN_W-1:0]  ZRUN_MAX   = 2'd2;
  localparam logic [SHIFT_W-1:0] SHIFT_STEP = 3'd2;
  localparam logic [SHIFT_W-1:0] SHIFT_LAST = 3'd6;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
  } bser_res_t;

  // up to two results produced by one request
  typedef struct packed {
    logic [1:0] cnt;
    bser_res_t  r1;
    bser_res_t  r0;
  } bser_push_t;

endpackage
`default_nettype wire

/* hdl/bser_ifs.sv */
// valid/ready channel interfaces for raw input and cleaned output bytes
`default_nettype none
interface bser_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] raw_byte;
  logic       chunk_end;

  modport source (output valid, output raw_byte, output chunk_end, input ready);
  modport sink (input valid, input raw_byte, input chunk_end, output ready);
endinterface

interface bser_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] clean_byte;
  logic       final_byte;

  modport source (output valid, output clean_byte, output final_byte, input ready);
  modport sink (input valid, input clean_byte, input final_byte, output ready);
endinterface
`default_nettype wire

/* hdl/bser_core.sv */
// stuffing removal state and repacking of one byte per request
`default_nettype none
module bser_core (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_fire,
  input  logic [7:0]               in_raw_byte,
  input  logic                     in_chunk_end,
  output bser_pkg::bser_push_t     push
);
  import bser_pkg::*;

  logic [ZRUN_W-1:0]  zrun_r, zrun_nxt;
  logic [SHIFT_W-1:0] shift_r, shift_nxt;
  logic               held_valid_r, held_valid_nxt;
  logic [BYTE_W-1:0]  held_high_r, held_high_nxt;

  logic [BYTE_W-1:0]  fill;
  logic [BYTE_W-1:0]  new_high;
  logic               new_valid;
  logic               is_stuff;
  logic               is_start;
  bser_res_t          held_res;
  bser_res_t          new_res;

  assign is_stuff = (zrun_r == ZRUN_MAX) && (in_raw_byte == STUFF_BYTE);
  assign is_start = (zrun_r == ZRUN_MAX) && (in_raw_byte == START_BYTE);

  // top bits of the incoming byte complete the pending byte
  always_comb begin
    unique case (shift_r)
      3'd2:    fill = {6'd0, in_raw_byte[7:6]};
      3'd4:    fill = {4'd0, in_raw_byte[7:4]};
      3'd6:    fill = {2'd0, in_raw_byte[7:2]};
      default: fill = '0;
    endcase
  end

  always_comb begin
    shift_nxt = shift_r;
    new_valid = 1'b1;
    new_high  = '0;
    if (is_stuff) begin
      // four removals drop a whole byte
      new_valid = (shift_r != SHIFT_LAST);
      shift_nxt = shift_r + SHIFT_STEP;
    end else if (is_start) begin
      shift_nxt = '0;
      new_high  = in_raw_byte;
    end else begin
      new_high  = in_raw_byte << shift_r;
    end
    if (in_raw_byte == '0) begin
      zrun_nxt = (zrun_r == ZRUN_MAX) ? ZRUN_MAX : zrun_r + 2'd1;
    end else begin
      zrun_nxt = '0;
    end
    held_valid_nxt = new_valid;
    held_high_nxt  = new_valid ? new_high : '0;
  end

  always_comb begin
    held_res.data = held_high_r | fill;
    held_res.last = in_chunk_end && !new_valid;
    new_res.data  = new_high;
    new_res.last  = 1'b1;
    push.r1       = new_res;
    if (held_valid_r) begin
      push.r0  = held_res;
      push.cnt = (in_chunk_end && new_valid) ? 2'd2 : 2'd1;
    end else begin
      push.r0  = new_res;
      push.cnt = (in_chunk_end && new_valid) ? 2'd1 : 2'd0;
    end
    if (!in_fire) begin
      push.cnt = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zrun_r       <= '0;
      shift_r      <= '0;
      held_valid_r <= 1'b0;
      held_high_r  <= '0;
    end else if (in_fire) begin
      if (in_chunk_end) begin
        zrun_r       <= '0;
        shift_r      <= '0;
        held_valid_r <= 1'b0;
        held_high_r  <= '0;
      end else begin
        zrun_r       <= zrun_nxt;
        shift_r      <= shift_nxt;
        held_valid_r <= held_valid_nxt;
        held_high_r  <= held_high_nxt;
      end
    end
  end

endmodule
`default_nettype wire

/* hdl/bser_outq.sv */
// small result queue taking up to two entries and giving one per cycle while out_ch.ready is high
`default_nettype none
module bser_outq (
  input  logic                 clk,
  input  logic                 rst_n,
  input  bser_pkg::bser_push_t push,
  output logic                 room,
  bser_out_if.source           out_ch
);
  import bser_pkg::*;

  localparam int unsigned AW = $clog2(OUTQ_DEPTH);
  localparam int unsigned CW = $clog2(OUTQ_DEPTH + 1);
  localparam logic [CW-1:0] ROOM_MAX = CW'(OUTQ_DEPTH - 2);

  bser_res_t         mem [OUTQ_DEPTH];
  logic [AW-1:0]     wptr_r, rptr_r;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic              pop;
  bser_res_t         head;

  assign head              = mem[rptr_r];
  assign out_ch.valid      = (cnt_r != '0);
  assign out_ch.clean_byte = head.data;
  assign out_ch.final_byte = head.last;
  assign pop               = out_ch.valid && out_ch.ready;
  assign room              = (cnt_r <= ROOM_MAX);
  assign cnt_nxt           = cnt_r + CW'(push.cnt) - CW'(pop);

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      mem[wptr_r] <= push.r0;
    end
    if (push.cnt == 2'd2) begin
      mem[wptr_r + AW'(1)] <= push.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_r + AW'(push.cnt);
      rptr_r <= rptr_r + AW'(pop);
      cnt_r  <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

/* hdl/bit_stuffing_emulation_remover.sv */
// top level of the bit stuffing emulation remover
// Takes one payload byte per request and removes the two stuffed bits carried
// by each 0x02 byte that follows two or more zero bytes, repacking later bytes
// by the accumulated bit offset; a 0x01 after two zeros passes and clears the
// offset. Each output byte waits for the next raw byte, so one byte is held
// pending and released on the following request or flushed on chunk_end,
// whose last output carries final_byte. Every request is processed in the
// cycle it is accepted, and one request can be taken each cycle while ready;
// results leave through a four-entry queue at one per cycle while out_ch.ready
// is high, and in_ch.ready is high while the queue has at least two free
// entries, so that a chunk's last byte, which can produce two results, fits.
`default_nettype none
module bit_stuffing_emulation_remover (
  input  logic       clk,
  input  logic       rst_n,
  bser_in_if.sink    in_ch,
  bser_out_if.source out_ch
);
  import bser_pkg::*;

  bser_push_t push;
  logic       room;
  logic       in_fire;

  assign in_ch.ready = room;
  assign in_fire     = in_ch.valid && room;

  bser_core u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_fire      (in_fire),
    .in_raw_byte  (in_ch.raw_byte),
    .in_chunk_end (in_ch.chunk_end),
    .push         (push)
  );

  bser_outq u_outq (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .room   (room),
    .out_ch (out_ch)
  );

endmodule
`default_nettype wire

/* tb/bit_stuffing_emulation_remover_test.sv */
// self-checking testbench: random byte streams with stuffed-bit runs, checked against a predictor
`timescale 1ns / 1ps
module bit_stuffing_emulation_remover_test;
  import bser_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 900;
  localparam int unsigned CALM_ITEMS   = 150;
  localparam int unsigned LONG_HOLD    = 200;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam bser_res_t   NO_RES       = '0;

  typedef struct packed {
    logic [BYTE_W-1:0] raw;
    logic              fin;
    logic              typed;
    logic [1:0]        n;
    bser_res_t         t0;
    bser_res_t         t1;
  } plan_row_t;

  logic clk;
  logic rst_n;

  bser_in_if  in_ch();
  bser_out_if out_ch();

  bit_stuffing_emulation_remover dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // predictor state
  logic [ZRUN_W-1:0]  zeros_seen  = '0;
  logic [SHIFT_W-1:0] offset_bits = '0;
  logic               held_ok     = 1'b0;
  logic [BYTE_W-1:0]  held_bits   = '0;

  bser_res_t   clean_byte_q [$];
  plan_row_t   plan [25];
  int unsigned errors      = 0;
  int unsigned cycles      = 0;
  bit          calm        = 1'b0;
  bit          squeeze_req = 1'b0;

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, clean_byte_q.size());
      $display("bit_stuffing_emulation_remover verification failed");
      $finish;
    end
  end

  task automatic flag_mismatch(input string what);
    $display("ERROR cycle %0d: %s", cycles, what);
    errors++;
  endtask

  function automatic int unsigned unstuff_byte(input logic [BYTE_W-1:0] raw, input logic fin,
                                               output bser_res_t r0, output bser_res_t r1);
    bser_res_t         made [2];
    logic [3:0]        sh;
    logic [BYTE_W-1:0] fill;
    logic [BYTE_W-1:0] next_bits;
    logic              keep;
    int unsigned       n;
    made[0] = NO_RES;
    made[1] = NO_RES;
    sh = {1'b0, offset_bits};
    n = 0;
    keep = 1'b1;
    next_bits = '0;
    // the pending byte takes its low bits from the top of this raw byte
    if (held_ok) begin
      fill = (sh == '0) ? '0 : raw >> (BYTE_W - sh);
      made[n] = '{data: held_bits | fill, last: 1'b0};
      n++;
    end
    if (zeros_seen >= ZRUN_MAX && raw == STUFF_BYTE) begin
      sh = sh + SHIFT_STEP;
      if (sh >= BYTE_W) begin
        sh = '0;
        keep = 1'b0;
      end
    end else if (zeros_seen >= ZRUN_MAX && raw == START_BYTE) begin
      sh = '0;
      next_bits = raw;
    end else begin
      next_bits = raw << sh;
    end
    if (raw == '0) begin
      zeros_seen = (zeros_seen >= ZRUN_MAX) ? ZRUN_MAX : zeros_seen + 1'b1;
    end else begin
      zeros_seen = '0;
    end
    offset_bits = sh[SHIFT_W-1:0];
    held_ok = keep;
    held_bits = keep ? next_bits : '0;
    if (fin) begin
      if (held_ok) begin
        made[n] = '{data: held_bits, last: 1'b1};
        n++;
      end else if (n > 0) begin
        made[n-1].last = 1'b1;
      end
      zeros_seen = '0;
      offset_bits = '0;
      held_ok = 1'b0;
      held_bits = '0;
    end
    r0 = made[0];
    r1 = made[1];
    return n;
  endfunction

  task automatic offer_byte(input logic [BYTE_W-1:0] raw, input logic fin, input logic typed,
                            input logic [1:0] n_typed, input bser_res_t t0, input bser_res_t t1);
    bser_res_t   p0;
    bser_res_t   p1;
    int unsigned cnt;
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.raw_byte  <= raw;
    in_ch.chunk_end <= fin;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    cnt = unstuff_byte(raw, fin, p0, p1);
    if (typed) begin
      cnt = {30'd0, n_typed};
      p0 = t0;
      p1 = t1;
    end
    if (cnt > 0) clean_byte_q.push_back(p0);
    if (cnt > 1) clean_byte_q.push_back(p1);
    @(negedge clk);
  endtask

  always @(posedge clk) begin
    bser_res_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (clean_byte_q.size() == 0) begin
        flag_mismatch($sformatf("unexpected byte %02h final %0b", out_ch.clean_byte,
                                out_ch.final_byte));
      end else begin
        want = clean_byte_q.pop_front();
        if (out_ch.clean_byte !== want.data)
          flag_mismatch($sformatf("clean_byte %02h, want %02h", out_ch.clean_byte, want.data));
        if (out_ch.final_byte !== want.last)
          flag_mismatch($sformatf("final_byte %0b, want %0b on byte %02h", out_ch.final_byte,
                                  want.last, want.data));
      end
    end
  end

  // result side: short random stalls plus one long hold to back up the block
  initial begin
    bit squeezed;
    squeezed = 1'b0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (squeeze_req && !squeezed) begin
        squeezed = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD - 1) @(negedge clk);
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(0, 18)) @(negedge clk);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    int unsigned       sent;
    int unsigned       clen;
    logic [BYTE_W-1:0] chunk_q [$];
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.raw_byte = '0;
    in_ch.chunk_end = 1'b0;
    plan = '{
      '{8'h00, 1'b0, 1'b1, 2'd0, NO_RES, NO_RES},            // nothing pending after reset
      '{8'h00, 1'b0, 1'b1, 2'd1, '{8'h00, 1'b0}, NO_RES},
      '{8'h02, 1'b0, 1'b1, 2'd1, '{8'h00, 1'b0}, NO_RES},    // first stuffed byte
      '{8'hFF, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
      '{8'h00, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
      '{8'h00, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
      '{8'h02, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
      '{8'h00, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
      '{8'h00, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
      '{8'h02, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
      '{8'h00, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
      '{8'h00, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
      '{8'h02, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},            // fourth removal drops a byte
      '{8'h80, 1'b1, 1'b0, 2'd0, NO_RES, NO_RES},            // end with nothing pending before
      '{8'hFF, 1'b1, 1'b1, 2'd1, '{8'hFF, 1'b1}, NO_RES},    // one-byte chunk
      '{8'h00, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
      '{8'h00, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
      '{8'h01, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},            // start code passes
      '{8'hA5, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
      '{8'h00, 1'b1, 1'b0, 2'd0, NO_RES, NO_RES},
      '{8'h00, 1'b1, 1'b1, 2'd1, '{8'h00, 1'b1}, NO_RES},
      '{8'h55, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
      '{8'h00, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
      '{8'h00, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
      '{8'h02, 1'b1, 1'b0, 2'd0, NO_RES, NO_RES}             // chunk ends on a stuffed byte
    };
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (plan[i])
      offer_byte(plan[i].raw, plan[i].fin, plan[i].typed, plan[i].n, plan[i].t0, plan[i].t1);

    squeeze_req <= 1'b1;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      clen = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 48);
      chunk_q.delete();
      while (chunk_q.size() < clen) begin
        if ($urandom_range(0, 2) == 0) begin
          // zero run followed by a stuffed or start code byte
          repeat ($urandom_range(2, 3)) chunk_q.push_back('0);
          chunk_q.push_back(($urandom_range(0, 5) == 0) ? START_BYTE : STUFF_BYTE);
        end else begin
          chunk_q.push_back(($urandom_range(0, 9) < 3) ? '0 : BYTE_W'($urandom));
        end
      end
      foreach (chunk_q[i])
        offer_byte(chunk_q[i], i == chunk_q.size() - 1, 1'b0, 2'd0, NO_RES, NO_RES);
      sent += chunk_q.size();
      if (sent >= RANDOM_ITEMS - CALM_ITEMS) calm <= 1'b1;
    end
    in_ch.valid <= 1'b0;

    while (clean_byte_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("bit_stuffing_emulation_remover verification clean");
    end else begin
      $display("bit_stuffing_emulation_remover verification failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
hdl/bser_pkg.sv
hdl/bser_ifs.sv
hdl/bser_core.sv
hdl/bser_outq.sv
hdl/bit_stuffing_emulation_remover.sv
tb/bit_stuffing_emulation_remover_test.sv
